### rtl/embedding_bag_sum_bf16_top_defines.svh
// Assertion macros for the RTL files of the embedding bag block.
`ifndef EMBEDDING_BAG_SUM_BF16_TOP_DEFINES_SVH
`define EMBEDDING_BAG_SUM_BF16_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define EBS_ASSERT(lbl, ck, rn, prop) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) \
        else $error("ebs assertion failed");
// Condition must never be seen outside reset.
`define EBS_NEVER(lbl, ck, rn, cond) \
    lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) \
        else $error("ebs forbidden condition seen");
`else
`define EBS_ASSERT(lbl, ck, rn, prop)
`define EBS_NEVER(lbl, ck, rn, cond)
`endif

`endif

### rtl/ebs_pkg.sv
package ebs_pkg;

    // Table geometry.
    localparam int HIDDEN     = 1024;
    localparam int NUM_BOOKS  = 8;
    localparam int TEXT_ROWS  = 4096;
    localparam int AUDIO_ROWS = 1024;

    localparam longint TEXT_WORDS  = longint'(TEXT_ROWS) * longint'(HIDDEN);
    localparam longint BOOK_WORDS  = longint'(AUDIO_ROWS) * longint'(HIDDEN);
    localparam longint AUDIO_WORDS = longint'(NUM_BOOKS) * BOOK_WORDS;
    localparam int TEXT_AW  = $clog2(TEXT_WORDS);
    localparam int AUDIO_AW = $clog2(AUDIO_WORDS);
    localparam int BOOK_IW  = $clog2(NUM_BOOKS + 1);

    // Function codes of an input item.
    localparam logic [1:0] FN_WRITE = 2'd0;
    localparam logic [1:0] FN_CODE  = 2'd1;
    localparam logic [1:0] FN_SUM   = 2'd2;

    localparam logic [11:0] PAD_RESET = 12'd1024;
    localparam logic [31:0] BF16_BIAS = 32'h0000_7fff;
    localparam logic [31:0] F32_QNAN  = 32'hffc0_0000;

    typedef struct packed {
        logic [1:0]  func;
        logic [3:0]  book;
        logic [11:0] row;
        logic [9:0]  col;
        logic [15:0] word;
    } in_item_t;

    typedef struct packed {
        logic [15:0] sum_word;
        logic [9:0]  out_col;
        logic        range_error;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TXT,
        ST_TXT_WT,
        ST_BK,
        ST_BK_WT,
        ST_ADD,
        ST_FIN
    } ebs_state_t;

    // Round an f32 pattern to bf16 with the wrapping bias add.
    function automatic logic [15:0] narrow_bf16(input logic [31:0] x);
        logic [31:0] r;
        r = x + BF16_BIAS + {31'b0, x[16]};
        return r[31:16];
    endfunction

endpackage

### rtl/ebs_ram.sv
module ebs_ram #(
    parameter int     WIDTH = 16,
    parameter longint DEPTH = 1024,
    localparam int    AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             en,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single port, registered read.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/ebs_fadd.sv
module ebs_fadd
    import ebs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic        done,
    output logic [31:0] y
);

    // Stage one: unpack, order by magnitude, align and add.
    logic [7:0]  ea, eb, ex, ey, d;
    logic [23:0] mx, my;
    logic        sx, sy, a_nan, b_nan, a_inf, b_inf, a_big;
    logic [26:0] my_ext, my_sh, lost_mask;
    logic        sticky;
    logic [27:0] sum;
    logic        spec;
    logic [31:0] spec_val;

    always_comb
    begin
        ea    = a[30:23];
        eb    = b[30:23];
        a_nan = (ea == 8'hff) && (a[22:0] != 23'd0);
        b_nan = (eb == 8'hff) && (b[22:0] != 23'd0);
        a_inf = (ea == 8'hff) && (a[22:0] == 23'd0);
        b_inf = (eb == 8'hff) && (b[22:0] == 23'd0);
        a_big = a[30:0] >= b[30:0];
        if (a_big)
        begin
            sx = a[31]; ex = (ea == 8'd0) ? 8'd1 : ea; mx = {ea != 8'd0, a[22:0]};
            sy = b[31]; ey = (eb == 8'd0) ? 8'd1 : eb; my = {eb != 8'd0, b[22:0]};
        end
        else
        begin
            sx = b[31]; ex = (eb == 8'd0) ? 8'd1 : eb; mx = {eb != 8'd0, b[22:0]};
            sy = a[31]; ey = (ea == 8'd0) ? 8'd1 : ea; my = {ea != 8'd0, a[22:0]};
        end
        d         = ex - ey;
        my_ext    = {my, 3'b000};
        lost_mask = ~({27{1'b1}} << d);
        if (d >= 8'd27)
        begin
            my_sh  = 27'd0;
            sticky = |my;
        end
        else
        begin
            my_sh  = my_ext >> d;
            sticky = |(my_ext & lost_mask);
        end
        my_sh[0] = my_sh[0] | sticky;
        if (sx == sy)
        begin
            sum = {1'b0, mx, 3'b000} + {1'b0, my_sh};
        end
        else
        begin
            sum = {1'b0, mx, 3'b000} - {1'b0, my_sh};
        end
        // Infinity and NaN bypass the datapath.
        spec     = 1'b1;
        spec_val = F32_QNAN;
        priority if (a_nan)
        begin
            spec_val = {a[31:23], 1'b1, a[21:0]};
        end
        else if (b_nan)
        begin
            spec_val = {b[31:23], 1'b1, b[21:0]};
        end
        else if (a_inf && b_inf && (a[31] != b[31]))
        begin
            spec_val = F32_QNAN;
        end
        else if (a_inf)
        begin
            spec_val = a;
        end
        else if (b_inf)
        begin
            spec_val = b;
        end
        else
        begin
            spec = 1'b0;
        end
    end

    logic        s1_valid_reg;
    logic        s1_sign_reg, s1_spec_reg;
    logic [7:0]  s1_exp_reg;
    logic [27:0] s1_sum_reg;
    logic [31:0] s1_spec_val_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            s1_sign_reg     <= (sum == 28'd0) ? (a[31] & b[31]) : sx;
            s1_exp_reg      <= ex;
            s1_sum_reg      <= sum;
            s1_spec_reg     <= spec;
            s1_spec_val_reg <= spec_val;
        end
    end

    // Stage two: leading zero count and normalising shift.
    logic [4:0]  lz, sh;
    logic [7:0]  room;
    logic [26:0] n;
    logic [8:0]  e;

    always_comb
    begin
        lz = 5'd27;
        for (int i = 0; i < 27; i++)
        begin
            if (s1_sum_reg[i])
            begin
                lz = 5'(26 - i);
            end
        end
        room = s1_exp_reg - 8'd1;
        sh   = ({3'b000, lz} > room) ? room[4:0] : lz;
        if (s1_sum_reg[27])
        begin
            n = {s1_sum_reg[27:2], s1_sum_reg[1] | s1_sum_reg[0]};
            e = {1'b0, s1_exp_reg} + 9'd1;
        end
        else
        begin
            n = s1_sum_reg[26:0] << sh;
            e = {1'b0, s1_exp_reg} - {4'b0000, sh};
            if (!n[26])
            begin
                e = 9'd0;
            end
        end
    end

    logic        s2_valid_reg;
    logic        s2_sign_reg, s2_spec_reg;
    logic [8:0]  s2_exp_reg;
    logic [26:0] s2_n_reg;
    logic [31:0] s2_spec_val_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_sign_reg     <= s1_sign_reg;
            s2_exp_reg      <= e;
            s2_n_reg        <= n;
            s2_spec_reg     <= s1_spec_reg;
            s2_spec_val_reg <= s1_spec_val_reg;
        end
    end

    // Stage three: round to nearest even and pack.
    logic        up;
    logic [30:0] body;
    logic [31:0] y_next;

    always_comb
    begin
        up   = s2_n_reg[2] & (s2_n_reg[1] | s2_n_reg[0] | s2_n_reg[3]);
        body = {s2_exp_reg[7:0], s2_n_reg[25:3]} + {30'd0, up};
        priority if (s2_spec_reg)
        begin
            y_next = s2_spec_val_reg;
        end
        else if (s2_exp_reg >= 9'd255)
        begin
            y_next = {s2_sign_reg, 8'hff, 23'd0};
        end
        else
        begin
            y_next = {s2_sign_reg, body};
        end
    end

    logic        done_reg;
    logic [31:0] y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            y_reg <= y_next;
        end
    end

    assign done = done_reg;
    assign y    = y_reg;

endmodule

### rtl/embedding_bag_sum_bf16_top.sv
// Channel   Direction  Signals                          Content
// in        input      in_valid, in_ready, in_data      write word, set code, sum column
// out       output     out_valid, out_ready, out_data   bf16 sum, column, range error
// cfg       input      cfg_valid, cfg_ready, cfg_data   pad code
//
// A write or set-code item is handled in the idle state. A sum item reads the
// text word, then for every codebook that contributes reads the audio word and
// adds it in a serial chain of f32 adds in the three-stage adder fed from the
// single-port audio memory; other codebooks are skipped, then the output loads.
// Reset clears the codes and sets the pad code; the tables hold no reset value.
// A finished result waits in the output register; the next item is taken
// meanwhile, and a sum stalls only if its result finds that register still full.
`include "embedding_bag_sum_bf16_top_defines.svh"

module embedding_bag_sum_bf16_top
    import ebs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [11:0] cfg_data
);

    ebs_state_t state_reg, state_next;

    logic [11:0]        pad_reg;
    logic [11:0]        codes_reg [NUM_BOOKS + 1];
    logic [BOOK_IW-1:0] book_idx_reg;
    logic [9:0]         col_reg;
    logic [31:0]        acc_reg;
    logic               err_reg;
    out_item_t          out_reg;
    logic               out_valid_reg;

    logic accept, in_col_ok, last, tok_ok, code_pad, code_oob;
    logic [11:0] cur_code;

    assign accept    = in_valid && in_ready;
    assign in_col_ok = 32'(in_data.col) < 32'(HIDDEN);
    assign cur_code  = codes_reg[book_idx_reg];
    assign code_pad  = cur_code == pad_reg;
    assign code_oob  = 32'(cur_code) >= 32'(AUDIO_ROWS);
    assign tok_ok    = 32'(codes_reg[0]) < 32'(TEXT_ROWS);
    assign last      = book_idx_reg == BOOK_IW'(NUM_BOOKS);

    // Adder interface.
    logic        add_start, add_done;
    logic [31:0] add_y;

    // Memory interface.
    logic                text_en, text_we, aud_en, aud_we;
    logic [TEXT_AW-1:0]  text_addr;
    logic [AUDIO_AW-1:0] aud_addr;
    logic [15:0]         text_rdata, aud_rdata;
    logic [11:0]         t_row, a_row;
    logic [9:0]          a_col;
    logic [BOOK_IW-1:0]  a_book;
    logic                load_out;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (in_data.func == FN_SUM) && in_col_ok)
                begin
                    state_next = ST_TXT;
                end
            end
            ST_TXT:    state_next = ST_TXT_WT;
            ST_TXT_WT: state_next = ST_BK;
            ST_BK:
            begin
                if (code_pad || code_oob)
                begin
                    state_next = last ? ST_FIN : ST_BK;
                end
                else
                begin
                    state_next = ST_BK_WT;
                end
            end
            ST_BK_WT:  state_next = ST_ADD;
            ST_ADD:
            begin
                if (add_done)
                begin
                    state_next = last ? ST_FIN : ST_BK;
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb
    begin
        in_ready  = 1'b0;
        text_en   = 1'b0;
        text_we   = 1'b0;
        aud_en    = 1'b0;
        aud_we    = 1'b0;
        add_start = 1'b0;
        load_out  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && (in_data.func == FN_WRITE) && in_col_ok)
                begin
                    if ((in_data.book == 4'd0) && (32'(in_data.row) < 32'(TEXT_ROWS)))
                    begin
                        text_en = 1'b1;
                        text_we = 1'b1;
                    end
                    if ((in_data.book != 4'd0) && (32'(in_data.book) <= 32'(NUM_BOOKS))
                        && (32'(in_data.row) < 32'(AUDIO_ROWS)))
                    begin
                        aud_en = 1'b1;
                        aud_we = 1'b1;
                    end
                end
            end
            ST_TXT:    text_en = tok_ok;
            ST_BK:     aud_en = !code_pad && !code_oob;
            ST_BK_WT:  add_start = 1'b1;
            ST_FIN:    load_out = !out_valid_reg || out_ready;
            default:
            begin
            end
        endcase
    end

    // Address formation: writes use the item, reads use the stored codes.
    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            t_row  = in_data.row;
            a_row  = in_data.row;
            a_col  = in_data.col;
            a_book = BOOK_IW'(in_data.book);
        end
        else
        begin
            t_row  = codes_reg[0];
            a_row  = cur_code;
            a_col  = col_reg;
            a_book = book_idx_reg;
        end
        text_addr = TEXT_AW'(t_row) * TEXT_AW'(HIDDEN) + TEXT_AW'(a_col);
        aud_addr  = AUDIO_AW'(a_book - BOOK_IW'(1)) * AUDIO_AW'(BOOK_WORDS)
                  + AUDIO_AW'(a_row) * AUDIO_AW'(HIDDEN) + AUDIO_AW'(a_col);
    end

    ebs_ram #(.WIDTH(16), .DEPTH(TEXT_WORDS)) u_text_ram (
        .clk   (clk),
        .en    (text_en),
        .we    (text_we),
        .addr  (text_addr),
        .wdata (in_data.word),
        .rdata (text_rdata)
    );

    ebs_ram #(.WIDTH(16), .DEPTH(AUDIO_WORDS)) u_audio_ram (
        .clk   (clk),
        .en    (aud_en),
        .we    (aud_we),
        .addr  (aud_addr),
        .wdata (in_data.word),
        .rdata (aud_rdata)
    );

    ebs_fadd u_fadd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (add_start),
        .a     (acc_reg),
        .b     ({aud_rdata, 16'h0000}),
        .done  (add_done),
        .y     (add_y)
    );

    // Control registers, codes and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pad_reg       <= PAD_RESET;
            out_valid_reg <= 1'b0;
            for (int i = 0; i <= NUM_BOOKS; i++)
            begin
                codes_reg[i] <= 12'd0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                pad_reg <= cfg_data;
            end
            if (accept && (in_data.func == FN_CODE) && (32'(in_data.book) <= 32'(NUM_BOOKS)))
            begin
                codes_reg[BOOK_IW'(in_data.book)] <= in_data.row;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Accumulator, error flag and book walk.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                col_reg      <= in_data.col;
                book_idx_reg <= BOOK_IW'(1);
            end
            ST_TXT_WT:
            begin
                acc_reg <= tok_ok ? {text_rdata, 16'h0000} : 32'd0;
                err_reg <= !tok_ok;
            end
            ST_BK:
            begin
                if (!code_pad && code_oob)
                begin
                    err_reg <= 1'b1;
                end
                if ((code_pad || code_oob) && !last)
                begin
                    book_idx_reg <= book_idx_reg + BOOK_IW'(1);
                end
            end
            ST_ADD:
            begin
                if (add_done)
                begin
                    acc_reg <= add_y;
                    if (!last)
                    begin
                        book_idx_reg <= book_idx_reg + BOOK_IW'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (load_out)
        begin
            out_reg.sum_word    <= narrow_bf16(acc_reg);
            out_reg.out_col     <= col_reg;
            out_reg.range_error <= err_reg;
        end
    end

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `EBS_ASSERT(a_done_in_add, clk, rst_n, add_done |-> (state_reg == ST_ADD))
    `EBS_ASSERT(a_fin_loads, clk, rst_n, load_out |=> out_valid_reg)
    `EBS_NEVER(a_no_pad_read, clk, rst_n, aud_en && !aud_we && code_pad)
    `EBS_ASSERT(a_book_range, clk, rst_n,
        (state_reg == ST_BK) |-> ((book_idx_reg != BOOK_IW'(0))
        && (32'(book_idx_reg) <= 32'(NUM_BOOKS))))

endmodule

### tb/sv/tb_embedding_bag_sum_bf16_top.sv
module tb_embedding_bag_sum_bf16_top;
    import ebs_pkg::*;

    // The unused function code gives no result and changes nothing.
    localparam logic [1:0] FN_SPARE = 2'd3;
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT = 2000000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_item_t in_data;
    logic out_valid;
    logic out_ready;
    out_item_t out_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [11:0] cfg_data;

    // Shadow state of the block.
    logic [15:0] text_mem [int];
    logic [15:0] audio_mem [int];
    logic [11:0] codes [0:NUM_BOOKS];
    logic [11:0] pad_value;

    out_item_t expected_sums [$];
    int errors;
    int items_sent;
    bit quiet;

    embedding_bag_sum_bf16_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // Run guard.
    initial
    begin
        int cycles;
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // IEEE single-precision add, round to nearest even, subnormals kept.
    function automatic logic [31:0] f32_add(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] x;
        logic [31:0] y;
        int ex;
        int ey;
        int d;
        logic [27:0] mx;
        logic [27:0] my;
        logic [27:0] m;
        logic stk;
        logic rnd;
        if (a[30:23] == 8'hff || b[30:23] == 8'hff)
        begin
            if (a[30:0] > 31'h7f80_0000)
                return a | 32'h0040_0000;
            if (b[30:0] > 31'h7f80_0000)
                return b | 32'h0040_0000;
            if (a[30:23] == 8'hff && b[30:23] == 8'hff && a[31] != b[31])
                return 32'hffc0_0000;
            return (a[30:23] == 8'hff) ? a : b;
        end
        x = a;
        y = b;
        if (b[30:0] > a[30:0])
        begin
            x = b;
            y = a;
        end
        ex = (x[30:23] == 0) ? 1 : int'(x[30:23]);
        ey = (y[30:23] == 0) ? 1 : int'(y[30:23]);
        mx = {1'b0, x[30:23] != 0, x[22:0], 3'b000};
        my = {1'b0, y[30:23] != 0, y[22:0], 3'b000};
        d = ex - ey;
        if (d >= 27)
            my = {27'b0, my != 0};
        else if (d > 0)
        begin
            stk = |(my & ((28'd1 << d) - 28'd1));
            my = (my >> d) | {27'b0, stk};
        end
        if (x[31] == y[31])
        begin
            m = mx + my;
            if (m[27])
            begin
                m = (m >> 1) | {27'b0, m[0]};
                ex++;
            end
        end
        else
        begin
            m = mx - my;
            if (m == 0)
                return 32'h0;
            while (!m[26] && ex > 1)
            begin
                m = m << 1;
                ex--;
            end
        end
        rnd = m[2] & (m[1] | m[0] | m[3]);
        m = (m >> 3) + {27'b0, rnd};
        if (m[24])
        begin
            m = m >> 1;
            ex++;
        end
        if (ex >= 255)
            return {x[31], 8'hff, 23'b0};
        return {x[31], m[23] ? ex[7:0] : 8'h00, m[22:0]};
    endfunction

    // Works out the result of one sum item from the shadow state.
    function automatic out_item_t column_sum(input logic [9:0] col);
        out_item_t res;
        logic [31:0] acc;
        logic [31:0] biased;
        logic err;
        err = 1'b0;
        if (codes[0] < TEXT_ROWS)
            acc = {text_mem[int'(codes[0]) * HIDDEN + int'(col)], 16'h0};
        else
        begin
            acc = 32'h0;
            err = 1'b1;
        end
        for (int b = 1; b <= NUM_BOOKS; b++)
        begin
            if (codes[b] == pad_value)
                continue;
            if (codes[b] < AUDIO_ROWS)
                acc = f32_add(acc, {audio_mem[((b - 1) * AUDIO_ROWS + int'(codes[b])) * HIDDEN
                                              + int'(col)], 16'h0});
            else
                err = 1'b1;
        end
        biased = acc + 32'h0000_7fff + {31'b0, acc[16]};
        res.sum_word = biased[31:16];
        res.out_col = col;
        res.range_error = err;
        return res;
    endfunction

    // Applies one accepted item to the shadow state.
    task automatic apply_item(input in_item_t it);
        if (it.func == FN_WRITE)
        begin
            if (it.book == 0)
                text_mem[int'(it.row) * HIDDEN + int'(it.col)] = it.word;
            else if (it.book <= NUM_BOOKS && it.row < AUDIO_ROWS)
                audio_mem[((int'(it.book) - 1) * AUDIO_ROWS + int'(it.row)) * HIDDEN
                          + int'(it.col)] = it.word;
        end
        else if (it.func == FN_CODE)
        begin
            if (it.book <= NUM_BOOKS)
                codes[it.book] = it.row;
        end
        else if (it.func == FN_SUM)
            expected_sums.insert(expected_sums.size(), column_sum(it.col));
    endtask

    // Valid stays high after acceptance until the caller drives the next item
    // or an idle gap in the same time step.
    task automatic send_item(input logic [1:0] func, input logic [3:0] book,
                             input logic [11:0] row, input logic [9:0] col,
                             input logic [15:0] word);
        in_item_t it;
        it.func = func;
        it.book = book;
        it.row = row;
        it.col = col;
        it.word = word;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do
            @(posedge clk);
        while (!in_ready);
        apply_item(it);
        items_sent++;
    endtask

    // Waits until every expected result has come and the block has gone quiet.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_sums.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_pad(input logic [11:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        pad_value = value;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly moderate magnitudes, some subnormals and zeros.
    function automatic logic [15:0] random_word();
        logic [7:0] e;
        case ($urandom_range(0, 9))
            0: e = 8'h00;
            1: e = 8'($urandom_range(0, 8'hf0));
            default: e = 8'($urandom_range(8'h70, 8'h8f));
        endcase
        return {1'($urandom), e, 7'($urandom)};
    endfunction

    // Writes every table entry that a sum over this column will read and that holds no value yet.
    task automatic fill_column(input logic [9:0] col);
        int idx;
        idx = int'(codes[0]) * HIDDEN + int'(col);
        if (codes[0] < TEXT_ROWS && !text_mem.exists(idx))
            send_item(FN_WRITE, 4'd0, codes[0], col, random_word());
        for (int b = 1; b <= NUM_BOOKS; b++)
        begin
            idx = ((b - 1) * AUDIO_ROWS + int'(codes[b])) * HIDDEN + int'(col);
            if (codes[b] != pad_value && codes[b] < AUDIO_ROWS && !audio_mem.exists(idx))
                send_item(FN_WRITE, 4'(b), codes[b], col, random_word());
        end
    endtask

    task automatic sum_column(input logic [9:0] col);
        fill_column(col);
        send_item(FN_SUM, 4'd0, 12'd0, col, 16'($urandom));
    endtask

    // Result checker.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_sums.size() == 0)
            begin
                $error("unexpected result item, col %0d", out_data.out_col);
                errors++;
            end
            else
            begin
                out_item_t exp_item;
                exp_item = expected_sums.pop_front();
                if (out_data.sum_word !== exp_item.sum_word)
                begin
                    $error("sum_word expected %h actual %h", exp_item.sum_word,
                           out_data.sum_word);
                    errors++;
                end
                if (out_data.out_col !== exp_item.out_col)
                begin
                    $error("out_col expected %0d actual %0d", exp_item.out_col,
                           out_data.out_col);
                    errors++;
                end
                if (out_data.range_error !== exp_item.range_error)
                begin
                    $error("range_error expected %b actual %b", exp_item.range_error,
                           out_data.range_error);
                    errors++;
                end
            end
        end
    end

    // Receiver stalls in bursts.
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            if (!quiet)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
        end
    end

    // Sums straight after reset: every code zero, all books contribute.
    task automatic test_reset_state();
        sum_column(10'd0);
        sum_column(10'd1023);
    endtask

    // Extreme words: NaN, largest finite, subnormals, zeros, cancellation, infinity.
    task automatic test_word_extremes();
        send_item(FN_CODE, 4'd0, 12'd4095, 10'd0, 16'h0);
        send_item(FN_CODE, 4'd1, 12'd1023, 10'd0, 16'h0);
        send_item(FN_CODE, 4'd2, 12'd7, 10'd0, 16'h0);
        for (int b = 3; b <= NUM_BOOKS; b++)
            send_item(FN_CODE, 4'(b), PAD_RESET, 10'd0, 16'h0);
        send_item(FN_WRITE, 4'd0, 12'd4095, 10'd5, 16'hffff);
        send_item(FN_WRITE, 4'd1, 12'd1023, 10'd5, 16'h7f7f);
        send_item(FN_WRITE, 4'd2, 12'd7, 10'd5, 16'h7f7f);
        sum_column(10'd5);
        send_item(FN_WRITE, 4'd1, 12'd1023, 10'd6, 16'h0001);
        send_item(FN_WRITE, 4'd2, 12'd7, 10'd6, 16'h8001);
        sum_column(10'd6);
        send_item(FN_CODE, 4'd0, 12'd3, 10'd0, 16'h0);
        send_item(FN_WRITE, 4'd0, 12'd3, 10'd6, 16'h8000);
        send_item(FN_WRITE, 4'd1, 12'd1023, 10'd7, 16'h3f80);
        send_item(FN_WRITE, 4'd2, 12'd7, 10'd7, 16'h7f80);
        sum_column(10'd7);
        sum_column(10'd6);
    endtask

    // Items the block must ignore, and out-of-range codes.
    task automatic test_ignored_items();
        send_item(FN_SPARE, 4'd15, 12'd4095, 10'd1023, 16'hffff);
        send_item(FN_WRITE, 4'd9, 12'd5, 10'd6, 16'h1234);
        send_item(FN_WRITE, 4'd15, 12'd5, 10'd6, 16'h1234);
        send_item(FN_WRITE, 4'd1, 12'd1024, 10'd6, 16'h1234);
        send_item(FN_WRITE, 4'd2, 12'd4095, 10'd6, 16'h1234);
        send_item(FN_CODE, 4'd15, 12'd9, 10'd0, 16'h0);
        send_item(FN_CODE, 4'd3, 12'd4095, 10'd0, 16'h0);
        send_item(FN_CODE, 4'd4, 12'd1024, 10'd0, 16'h0);
        sum_column(10'd6);
    endtask

    // Pad code at its extremes and on an in-range code.
    task automatic test_pad_settings();
        set_pad(12'd0);
        send_item(FN_CODE, 4'd5, 12'd0, 10'd0, 16'h0);
        sum_column(10'd6);
        set_pad(12'd4095);
        sum_column(10'd6);
        set_pad(12'd7);
        sum_column(10'd6);
        set_pad(PAD_RESET);
        sum_column(10'd6);
    endtask

    // Code sets with random content, then sums over a few columns, plus noise.
    task automatic test_random(input int count);
        int stop;
        stop = items_sent + count;
        while (items_sent < stop)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                case ($urandom_range(0, 2))
                    0: send_item(FN_SPARE, 4'($urandom), 12'($urandom), 10'($urandom),
                                 16'($urandom));
                    1: send_item(FN_WRITE, 4'($urandom_range(9, 15)), 12'($urandom),
                                 10'($urandom), 16'($urandom));
                    default: send_item(FN_CODE, 4'($urandom_range(9, 15)), 12'($urandom),
                                       10'd0, 16'h0);
                endcase
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    logic [3:0] b;
                    logic [11:0] code;
                    b = 4'($urandom_range(0, NUM_BOOKS));
                    case ($urandom_range(0, 7))
                        0: code = pad_value;
                        1: code = 12'($urandom);
                        default: code = 12'($urandom_range(0, 15));
                    endcase
                    send_item(FN_CODE, b, code, 10'd0, 16'h0);
                end
                repeat ($urandom_range(1, 3))
                    sum_column(($urandom_range(0, 1) == 0) ? 10'($urandom_range(0, 7))
                                                           : 10'($urandom));
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        errors = 0;
        items_sent = 0;
        quiet = 1'b0;
        pad_value = PAD_RESET;
        for (int b = 0; b <= NUM_BOOKS; b++)
            codes[b] = 12'd0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_word_extremes();
        test_ignored_items();
        test_pad_settings();
        test_random(250);
        set_pad(12'($urandom));
        test_random(250);
        set_pad(12'($urandom_range(0, 15)));
        quiet = 1'b1;
        test_random(200);

        wait_idle();
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
